// ===== hw/rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the page frame allocator
// Command and result codes, controller op codes, control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Field widths fixed by the item format
  localparam int BASE_W = 28;
  localparam int LEN_W  = 29;
  localparam int SUM_W  = 30;              // base + length, base + page - 1

  // Commands
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REGION = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_CLIP  = 2'd2;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_LATCH     = 4'd1;
  localparam logic [3:0] OP_POP_EMPTY = 4'd2;
  localparam logic [3:0] OP_POP_RD    = 4'd3;
  localparam logic [3:0] OP_POP_WR    = 4'd4;
  localparam logic [3:0] OP_FREE      = 4'd5;
  localparam logic [3:0] OP_CLEAR     = 4'd6;
  localparam logic [3:0] OP_REG_SKIP  = 4'd7;
  localparam logic [3:0] OP_SETUP     = 4'd10;
  localparam logic [3:0] OP_WALK      = 4'd11;
  localparam logic [3:0] OP_REG_DONE  = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       load;      // result register takes this op's result
  } pfa_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       usable;
    logic       head_zero;
    logic       walk_end;
  } pfa_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfa_ctrl: allocator sequencer
// Steps each item through latch, execute, pop and page walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire pfa_pkg::pfa_stat_t st,
  output pfa_pkg::pfa_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [3:0] op;
  logic       slot_free;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    op         = pfa_pkg::OP_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         = pfa_pkg::OP_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.cmd)
          pfa_pkg::CMD_ALLOC: begin
            if (!st.head_zero) begin
              op         = pfa_pkg::OP_POP_RD;
              state_next = S_POP;
            end else if (slot_free) begin
              op         = pfa_pkg::OP_POP_EMPTY;
              state_next = S_IDLE;
            end
          end
          pfa_pkg::CMD_FREE: begin
            if (slot_free) begin
              op         = pfa_pkg::OP_FREE;
              state_next = S_IDLE;
            end
          end
          pfa_pkg::CMD_REGION: begin
            if (st.usable) begin
              op         = pfa_pkg::OP_SETUP;
              state_next = S_WALK;
            end else if (slot_free) begin
              op         = pfa_pkg::OP_REG_SKIP;
              state_next = S_IDLE;
            end
          end
          pfa_pkg::CMD_CLEAR: begin
            if (slot_free) begin
              op         = pfa_pkg::OP_CLEAR;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (slot_free) begin
          op         = pfa_pkg::OP_POP_WR;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (!st.walk_end) begin
          op = pfa_pkg::OP_WALK;
        end else if (slot_free) begin
          op         = pfa_pkg::OP_REG_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ctl.op   = op;
  assign ctl.load = (op == pfa_pkg::OP_POP_EMPTY) || (op == pfa_pkg::OP_POP_WR) ||
                    (op == pfa_pkg::OP_FREE) || (op == pfa_pkg::OP_CLEAR) ||
                    (op == pfa_pkg::OP_REG_SKIP) || (op == pfa_pkg::OP_REG_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> slot_free)
    else $error("result loaded over pending result");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before accept");

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_dp.sv =====
// ----------------------------------------------------------------------------
// pfa_dp: allocator datapath
// Link memory, head and counts, page rounding, region walker,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_dp #(
  parameter int FRAMES     = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pfa_pkg::pfa_ctl_t          ctl,
  output pfa_pkg::pfa_stat_t              st,
  input  wire logic [1:0]                 cmd,
  input  wire logic [15:0]                frame_in,
  input  wire logic [pfa_pkg::BASE_W-1:0] region_base,
  input  wire logic [pfa_pkg::LEN_W-1:0]  region_length,
  input  wire logic                       region_usable,
  output logic [15:0]                     frame_out,
  output logic [16:0]                     free_pages,
  output logic [16:0]                     total_pages,
  output logic [1:0]                      status
);

  localparam int FW = $clog2(FRAMES);          // frame index
  localparam int CW = $clog2(FRAMES) + 1;      // counts, cursor (hold FRAMES)
  localparam int PW = $clog2(PAGE_BYTES);      // page shift, PAGE_BYTES is 2**PW
  localparam int DW = pfa_pkg::SUM_W;

  // latched item
  logic [1:0]                 cmd_r;
  logic [15:0]                fin_r;
  logic [pfa_pkg::BASE_W-1:0] base_r;
  logic [pfa_pkg::LEN_W-1:0]  len_r;
  logic                       usable_r;

  logic [FW-1:0] mem [FRAMES];
  logic [FW-1:0] rd_data;
  logic [FW-1:0] pop_frame;

  logic [FW-1:0] head,      head_next;
  logic [CW-1:0] free_cnt,  free_next;
  logic [CW-1:0] total_cnt, total_next;
  logic [CW-1:0] cursor,    cursor_next;
  logic [CW-1:0] stop_r;
  logic          walk_empty;
  logic [1:0]    reg_status;

  // page rounding: base rounded up, region end rounded down
  logic [DW-1:0] end_a, end_b;

  logic          wr_en;
  logic [FW-1:0] wr_addr;
  logic [FW-1:0] wr_data;
  logic [15:0]   out_frame_next;
  logic [1:0]    out_status_next;

  logic [31:0]   fin32, first32, stop32, qa32, qb32, pop32, free32, total32;
  logic          clip, empty;
  logic [CW-1:0] free_inc;
  logic [CW-1:0] total_inc;

  assign end_a   = DW'(base_r) + DW'(PAGE_BYTES - 1);
  assign end_b   = DW'(base_r) + DW'(len_r);

  assign fin32   = 32'(fin_r);
  assign qa32    = 32'(end_a >> PW);
  assign qb32    = 32'(end_b >> PW);
  assign clip    = qb32 > 32'(FRAMES);
  assign stop32  = clip ? 32'(FRAMES) : qb32;
  assign first32 = (qa32 == 32'd0) ? 32'd1 : qa32;
  assign empty   = first32 >= stop32;

  assign free_inc  = (free_cnt == CW'(FRAMES)) ? free_cnt : free_cnt + 1'b1;
  assign total_inc = (total_cnt == CW'(FRAMES)) ? total_cnt : total_cnt + 1'b1;

  assign pop32 = 32'(pop_frame);

  always_comb begin
    head_next       = head;
    free_next       = free_cnt;
    total_next      = total_cnt;
    cursor_next     = cursor;
    wr_en           = 1'b0;
    wr_addr         = cursor[FW-1:0];
    wr_data         = head;
    out_frame_next  = '0;
    out_status_next = pfa_pkg::ST_OK;
    unique case (ctl.op)
      pfa_pkg::OP_POP_EMPTY: begin
        out_status_next = pfa_pkg::ST_EMPTY;
      end
      pfa_pkg::OP_POP_WR: begin
        head_next      = rd_data;
        free_next      = (free_cnt == '0) ? free_cnt : free_cnt - 1'b1;
        out_frame_next = pop32[15:0];
      end
      pfa_pkg::OP_FREE: begin
        if (fin32 >= 32'(FRAMES)) begin
          out_status_next = pfa_pkg::ST_CLIP;
        end else if (fin_r != 16'd0) begin
          wr_en     = 1'b1;
          wr_addr   = fin32[FW-1:0];
          head_next = fin32[FW-1:0];
          free_next = free_inc;
        end
      end
      pfa_pkg::OP_CLEAR: begin
        head_next   = '0;
        free_next   = '0;
        total_next  = '0;
        cursor_next = '0;
      end
      pfa_pkg::OP_SETUP: begin
        if (!empty) begin
          cursor_next = first32[CW-1:0];
        end
      end
      pfa_pkg::OP_WALK: begin
        wr_en       = 1'b1;
        head_next   = cursor[FW-1:0];
        free_next   = free_inc;
        total_next  = total_inc;
        cursor_next = cursor + 1'b1;
      end
      pfa_pkg::OP_REG_DONE: begin
        out_status_next = reg_status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      free_cnt  <= '0;
      total_cnt <= '0;
      cursor    <= '0;
    end else begin
      head      <= head_next;
      free_cnt  <= free_next;
      total_cnt <= total_next;
      cursor    <= cursor_next;
    end
  end

  // link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.op == pfa_pkg::OP_POP_RD) begin
      rd_data   <= mem[head];
      pop_frame <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == pfa_pkg::OP_LATCH) begin
      cmd_r    <= cmd;
      fin_r    <= frame_in;
      base_r   <= region_base;
      len_r    <= region_length;
      usable_r <= region_usable;
    end
    if (ctl.op == pfa_pkg::OP_SETUP) begin
      stop_r     <= stop32[CW-1:0];
      walk_empty <= empty;
      reg_status <= (clip && (qb32 > qa32)) ? pfa_pkg::ST_CLIP : pfa_pkg::ST_OK;
    end
  end

  // result register
  assign free32  = 32'(free_next);
  assign total32 = 32'(total_next);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frame_out   <= out_frame_next;
      status      <= out_status_next;
      free_pages  <= free32[16:0];
      total_pages <= total32[16:0];
    end
  end

  assign st.cmd       = cmd_r;
  assign st.usable    = usable_r;
  assign st.head_zero = (head == '0);
  assign st.walk_end  = walk_empty || (cursor == stop_r);

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CW'(FRAMES))
    else $error("free count above frame count");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_cnt <= CW'(FRAMES))
    else $error("total count above frame count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.op == pfa_pkg::OP_WALK |-> cursor < stop_r)
    else $error("walk cursor past region end");

endmodule

`default_nettype wire

// ===== hw/rtl/page_frame_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_unit: LIFO page frame allocator
// Free frames chained through a link memory; alloc pops, free pushes,
// region add pushes every whole page of a byte range, except frame 0 and frames past FRAMES.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  req     | req_valid/req_ready  | cmd, frame_in, region_base, region_length,
//          |                      | region_usable
//  rsp     | rsp_valid/rsp_ready  | frame_out, free_pages, total_pages, status
//
//  Alloc makes one registered link-memory read before the head moves.
//  Region add accepts the item, rounds the page bounds by shift, then pushes
//  one page per cycle, set by the single link-memory write port, and posts
//  the result once the walk reaches the rounded region end.
//  PAGE_BYTES must be a power of two. The next item is taken while a result
//  waits; execution holds only at the point of loading a result if the result
//  register is still full. Reset clears head, counts and the sequencer; the
//  link memory is not cleared (it is only read at frames already pushed).
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_free_list_allocator_unit #(
  parameter int FRAMES     = 65536,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // request item
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [1:0]                 cmd,
  input  wire logic [15:0]                frame_in,
  input  wire logic [pfa_pkg::BASE_W-1:0] region_base,
  input  wire logic [pfa_pkg::LEN_W-1:0]  region_length,
  input  wire logic                       region_usable,
  // result item
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic [15:0]                     frame_out,
  output logic [16:0]                     free_pages,
  output logic [16:0]                     total_pages,
  output logic [1:0]                      status
);

  pfa_pkg::pfa_ctl_t  ctl;   // op for this cycle, result load
  pfa_pkg::pfa_stat_t st;    // latched command and usable flag, head empty, walk done

  // sequencer: one item at a time, result register decoupled
  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .ctl       (ctl)
  );

  // link memory, head/counts, page rounding, walker, result register
  pfa_dp #(
    .FRAMES     (FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .cmd           (cmd),
    .frame_in      (frame_in),
    .region_base   (region_base),
    .region_length (region_length),
    .region_usable (region_usable),
    .frame_out     (frame_out),
    .free_pages    (free_pages),
    .total_pages   (total_pages),
    .status        (status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/page_frame_free_list_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_unit_tb: self-checking bench for the allocator
// Sends alloc, free, region and clear items with random idling on both
// channels. A behavioral copy of the free list predicts every result, and
// each result is checked field by field, in order, against that prediction.
// ----------------------------------------------------------------------------

module page_frame_free_list_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES       = 65536;
  localparam int PAGE_BYTES   = 4096;
  localparam int RUN_ITEMS    = 1300;     // random items after the directed set
  localparam int BIG_EVERY    = 400;      // one region of half to full space every so often
  localparam int IDLE_LIMIT   = 300000;   // watchdog limit; covers a full-space region walk + stalls
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [1:0]                 cmd;
    logic [15:0]                frame;
    logic [pfa_pkg::BASE_W-1:0] base;
    logic [pfa_pkg::LEN_W-1:0]  len;
    logic                       usable;
  } page_req_t;

  typedef struct {
    logic [15:0] frame;
    logic [16:0] free_pages;
    logic [16:0] total_pages;
    logic [1:0]  status;
  } page_rsp_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  logic [1:0]                 cmd = pfa_pkg::CMD_ALLOC;
  logic [15:0]                frame_in = '0;
  logic [pfa_pkg::BASE_W-1:0] region_base = '0;
  logic [pfa_pkg::LEN_W-1:0]  region_length = '0;
  logic                       region_usable = 1'b0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  logic [15:0]                frame_out;
  logic [16:0]                free_pages;
  logic [16:0]                total_pages;
  logic [1:0]                 status;

  page_frame_free_list_allocator_unit #(
    .FRAMES     (FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .cmd           (cmd),
    .frame_in      (frame_in),
    .region_base   (region_base),
    .region_length (region_length),
    .region_usable (region_usable),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .frame_out     (frame_out),
    .free_pages    (free_pages),
    .total_pages   (total_pages),
    .status        (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  page_req_t   cmd_backlog[$];   // items waiting for the driver
  page_rsp_t   due_rsp[$];       // predicted results, oldest first
  logic [15:0] handed_out[$];    // frames given out, reused for well-formed frees
  page_req_t   on_bus;           // item currently presented on the req channel
  page_rsp_t   want_rsp;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned fail_cnt = 0;
  bit          steady = 1'b0;    // no idling on either side while set

  // run statistics
  int unsigned n_alloc = 0, n_empty = 0, n_free = 0, n_region = 0;
  int unsigned n_clip = 0, n_clear = 0, pages_pushed = 0, peak_free = 0;

  // --------------------------------------------------------------------------
  // Free-list predictor: link memory, top of chain, counts, walk position
  // --------------------------------------------------------------------------
  logic [15:0] link_mem [FRAMES];
  logic [15:0] top_frame = '0;
  logic [16:0] free_cnt  = '0;
  logic [16:0] total_cnt = '0;
  logic [15:0] walk_pos  = '0;

  function automatic void push_frame(int unsigned f);
    link_mem[f] = top_frame;
    top_frame   = f[15:0];
    if (free_cnt < FRAMES) free_cnt++;
    pages_pushed++;
  endfunction

  // Pushes every whole page of [base, base+len) in ascending order, except frame 0 and frames past FRAMES.
  function automatic logic [1:0] add_region(logic [pfa_pkg::BASE_W-1:0] base,
                                            logic [pfa_pkg::LEN_W-1:0] len);
    longint unsigned first, stop, f;
    logic [1:0]      st;
    st    = pfa_pkg::ST_OK;
    first = (64'(base) + PAGE_BYTES - 1) / PAGE_BYTES;   // base rounds up
    stop  = (64'(base) + 64'(len)) / PAGE_BYTES;         // end rounds down
    if (stop > FRAMES) begin
      // pages past the covered space are dropped; flag only if any existed
      if (stop > first) st = pfa_pkg::ST_CLIP;
      stop = 64'(FRAMES);
    end
    if (first == 0) first = 64'd1;   // frame 0 marks the empty chain
    for (f = first; f < stop; f++) begin
      walk_pos = f[15:0];
      push_frame(32'(f));
      if (total_cnt < FRAMES) total_cnt++;
    end
    if (first < stop) walk_pos = stop[15:0];
    return st;
  endfunction

  function automatic void step_free_list(page_req_t r);
    page_rsp_t o;
    o.frame  = '0;
    o.status = pfa_pkg::ST_OK;
    case (r.cmd)
      pfa_pkg::CMD_ALLOC: begin
        if (top_frame == 0) begin
          o.status = pfa_pkg::ST_EMPTY;   // empty chain: nothing moves
          n_empty++;
        end else begin
          o.frame   = top_frame;
          top_frame = link_mem[top_frame];
          if (free_cnt > 0) free_cnt--;
          n_alloc++;
          handed_out.push_back(o.frame);
          if (handed_out.size() > 256) void'(handed_out.pop_front());
        end
      end
      pfa_pkg::CMD_FREE: begin
        n_free++;
        // frame 0 is silently ignored; double frees are pushed again
        if (r.frame >= FRAMES) o.status = pfa_pkg::ST_CLIP;
        else if (r.frame != 0) push_frame(32'(r.frame));
      end
      pfa_pkg::CMD_REGION: begin
        n_region++;
        if (r.usable) o.status = add_region(r.base, r.len);
        if (o.status == pfa_pkg::ST_CLIP) n_clip++;
      end
      default: begin
        // link memory keeps its contents across a clear
        top_frame = '0;
        free_cnt  = '0;
        total_cnt = '0;
        walk_pos  = '0;
        n_clear++;
      end
    endcase
    o.free_pages  = free_cnt;
    o.total_pages = total_cnt;
    if (32'(free_cnt) > peak_free) peak_free = 32'(free_cnt);
    due_rsp.push_back(o);
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long; none in steady phases
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predicts at acceptance, then presents the next item after a gap.
  // Valid is assigned once per edge, so back-to-back items keep it high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        step_free_list(on_bus);
        n_taken++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          on_bus         = cmd_backlog.pop_front();
          cmd           <= on_bus.cmd;
          frame_in      <= on_bus.frame;
          region_base   <= on_bus.base;
          region_length <= on_bus.len;
          region_usable <= on_bus.usable;
          req_valid     <= 1'b1;
          send_gap       = idle_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result, then stalls ready for a random time
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          $error("result item with none expected: frame_out %0d status %0d",
                 frame_out, status);
          fail_cnt++;
        end else begin
          want_rsp = due_rsp.pop_front();
          if (frame_out !== want_rsp.frame) begin
            $error("frame_out: expected %0d, got %0d", want_rsp.frame, frame_out);
            fail_cnt++;
          end
          if (free_pages !== want_rsp.free_pages) begin
            $error("free_pages: expected %0d, got %0d",
                   want_rsp.free_pages, free_pages);
            fail_cnt++;
          end
          if (total_pages !== want_rsp.total_pages) begin
            $error("total_pages: expected %0d, got %0d",
                   want_rsp.total_pages, total_pages);
            fail_cnt++;
          end
          if (status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, status);
            fail_cnt++;
          end
        end
        hold_left = idle_len();
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("FAIL page_frame_free_list_allocator_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic page_req_t mk_item(logic [1:0] c, logic [15:0] f,
                                        logic [pfa_pkg::BASE_W-1:0] b,
                                        logic [pfa_pkg::LEN_W-1:0] l, logic u);
    page_req_t r;
    r.cmd    = c;
    r.frame  = f;
    r.base   = b;
    r.len    = l;
    r.usable = u;
    return r;
  endfunction

  task automatic queue_item(page_req_t r);
    cmd_backlog.push_back(r);
    n_queued++;
  endtask

  // Random item; fields a command ignores carry random junk.
  function automatic page_req_t random_item(int unsigned idx);
    page_req_t   r;
    int unsigned sel, k, j;
    r.cmd    = pfa_pkg::CMD_ALLOC;
    r.frame  = 16'($urandom);
    r.base   = 28'($urandom);
    r.len    = 29'($urandom);
    r.usable = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (idx % BIG_EVERY == BIG_EVERY - 1) begin
      // half to full space from the bottom: long walk, deep chain
      r.cmd    = pfa_pkg::CMD_REGION;
      r.usable = 1'b1;
      r.base   = 28'($urandom_range(0, PAGE_BYTES - 1));
      r.len    = 29'($urandom_range(1 << 27, 1 << 28));
    end else if (sel < 36) begin
      r.cmd = pfa_pkg::CMD_ALLOC;
    end else if (sel < 62) begin
      r.cmd = pfa_pkg::CMD_FREE;
      k = $urandom_range(0, 9);
      if (k < 6 && handed_out.size() > 0) begin
        // give back a frame that was actually handed out
        j       = $urandom_range(0, handed_out.size() - 1);
        r.frame = handed_out[j];
        handed_out.delete(j);
      end else if (k < 8) begin
        r.frame = 16'($urandom_range(0, 255));
      end
    end else if (sel < 96) begin
      r.cmd    = pfa_pkg::CMD_REGION;
      r.usable = ($urandom_range(0, 9) != 0);
      k = $urandom_range(0, 9);
      if (k < 7) begin
        // a few dozen pages anywhere, sometimes page aligned
        r.len = 29'($urandom_range(0, 40 * PAGE_BYTES));
        if ($urandom_range(0, 2) == 0) begin
          r.base[11:0] = '0;
          r.len[11:0]  = '0;
        end
      end else begin
        // region near the top of the space; large lengths get clipped
        r.base = 28'((1 << 28) - 1 - $urandom_range(0, 40) * PAGE_BYTES
                     - $urandom_range(0, PAGE_BYTES - 1));
        r.len  = (k == 9) ? 29'(1 << 28) : 29'($urandom_range(0, 1 << 28));
      end
    end else begin
      r.cmd = pfa_pkg::CMD_CLEAR;
    end
    return r;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty alloc, frame 0 and top frame, one frame pushed and popped
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'hFFFF, 28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd1,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    // regions: unusable, frame 0 skipped, rounding, empty, inverted
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'hFFFF, 28'hFFFFFFF, 29'h10000000, 1'b0));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'd0,       29'd20480,    1'b1));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'd1,       29'd12288,    1'b1));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'h0123000, 29'd0,        1'b1));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'd4097,    29'd100,      1'b1));
    // clipped at the top: one page kept, then none kept but still flagged
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'hFFFF000, 29'h10000000, 1'b1));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'hFFFFFFF, 29'h10000000, 1'b1));
    // double free makes a self loop; free count bottoms out at zero
    queue_item(mk_item(pfa_pkg::CMD_CLEAR,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd5,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd5,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    // whole space, then both counts saturate
    queue_item(mk_item(pfa_pkg::CMD_CLEAR,  16'd0,    28'd0,       29'd0,        1'b1));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'd0,       29'h10000000, 1'b1));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd7,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_FREE,   16'd9,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_REGION, 16'd0,    28'd0,       29'd12288,    1'b1));
    queue_item(mk_item(pfa_pkg::CMD_ALLOC,  16'd0,    28'd0,       29'd0,        1'b0));
    queue_item(mk_item(pfa_pkg::CMD_CLEAR,  16'd0,    28'd0,       29'd0,        1'b0));

    // random part, fed a few items ahead so frees can reuse handed-out frames
    for (int unsigned i = 0; i < RUN_ITEMS; i++) begin
      while (cmd_backlog.size() >= 4) @(posedge clk);
      steady = ((i / 130) % 4 == 3);
      queue_item(random_item(i));
    end

    while (n_taken < n_queued || due_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items; %0d frames handed out, %0d empty allocs, %0d frees,",
             n_taken, n_alloc, n_empty, n_free);
    $display("     %0d regions (%0d clipped), %0d clears, %0d pages pushed, peak free %0d, walk at %0d",
             n_region, n_clip, n_clear, pages_pushed, peak_free, walk_pos);
    if (fail_cnt == 0 && due_rsp.size() == 0)
      $display("PASS page_frame_free_list_allocator_unit");
    else
      $display("FAIL page_frame_free_list_allocator_unit");
    $finish;
  end

endmodule
